/* design/espi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed PI controller package
// Shared register map, configuration type and fixed constants.
// ----------------------------------------------------------------------------
package espi_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_W      = 16;

    localparam logic [REG_W-1:0] RST_REF_SPEED   = 16'd0;
    localparam logic [REG_W-1:0] RST_SPEED_SCALE = 16'd150;
    localparam logic [REG_W-1:0] RST_GAIN_NOW    = 16'd2815;
    localparam logic [REG_W-1:0] RST_GAIN_PREV   = 16'd2782;

    localparam int GAIN_FRAC     = 16;
    localparam int DRIVE_MAX_INT = 12;
    localparam int DUTY_FULL     = 1000;
    // Reciprocal of twelve, scaled by 2^17; exact for dividends below 32768.
    localparam int DUTY_RECIP       = 10923;
    localparam int DUTY_RECIP_SHIFT = 17;

    typedef enum logic [1:0] {
        REG_REF_SPEED   = 2'd0,
        REG_SPEED_SCALE = 2'd1,
        REG_GAIN_NOW    = 2'd2,
        REG_GAIN_PREV   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] ref_speed;
        logic [REG_W-1:0] speed_scale;
        logic [REG_W-1:0] gain_now;
        logic [REG_W-1:0] gain_prev;
    } t_cfg;

endpackage

/* design/espi_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed PI controller register file
// APB-style configuration registers for reference, scale and gains.
// ----------------------------------------------------------------------------
module espi_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [espi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [espi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [espi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output espi_pkg::t_cfg                   o_cfg
);

    espi_pkg::t_cfg     r_cfg;
    espi_pkg::t_reg_idx reg_idx;
    logic               wr_en;
    logic [espi_pkg::REG_W-1:0] rd_val;
    logic [espi_pkg::REG_W-1:0] wr_val;

    assign pready  = 1'b1;
    assign reg_idx = espi_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_val  = pwdata[espi_pkg::REG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_speed   <= espi_pkg::RST_REF_SPEED;
            r_cfg.speed_scale <= espi_pkg::RST_SPEED_SCALE;
            r_cfg.gain_now    <= espi_pkg::RST_GAIN_NOW;
            r_cfg.gain_prev   <= espi_pkg::RST_GAIN_PREV;
        end else if (wr_en) begin
            unique case (reg_idx)
                espi_pkg::REG_REF_SPEED:   r_cfg.ref_speed   <= wr_val;
                espi_pkg::REG_SPEED_SCALE: r_cfg.speed_scale <= wr_val;
                espi_pkg::REG_GAIN_NOW:    r_cfg.gain_now    <= wr_val;
                espi_pkg::REG_GAIN_PREV:   r_cfg.gain_prev   <= wr_val;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            espi_pkg::REG_REF_SPEED:   rd_val = r_cfg.ref_speed;
            espi_pkg::REG_SPEED_SCALE: rd_val = r_cfg.speed_scale;
            espi_pkg::REG_GAIN_NOW:    rd_val = r_cfg.gain_now;
            espi_pkg::REG_GAIN_PREV:   rd_val = r_cfg.gain_prev;
        endcase
    end

    assign prdata = espi_pkg::APB_DATA_W'(rd_val);
    assign o_cfg  = r_cfg;

endmodule

/* design/encoder_speed_pi_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed PI controller
// Quadrature position counter with an incremental PI speed loop and duty out.
// ----------------------------------------------------------------------------
// Input beats with tuser low are channel A rising edges; they only move the
// position count, give no result and are always taken. Beats with tuser high
// are sample ticks; each gives one result beat at the end of the pipeline, and
// a tick can be taken in every cycle while the output drains.
// The pipeline has six stages: count difference, speed product, error gain
// products, drive update, and two stages of duty scaling.
module encoder_speed_pi_controller_unit #(
    parameter int COUNT_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [0] phase_b
    input  logic                             s_axis_tuser,  // [0] opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] pwm_duty, [25:10] speed, [26] drive_clamped
    output logic [31:0]                      m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [espi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [espi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [espi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int PROD_W  = COUNT_WIDTH + 17;
    localparam int ERR_W   = 18;
    localparam int GP_W    = 17 + ERR_W;
    localparam int UP_SH   = (FRAC_BITS >= espi_pkg::GAIN_FRAC) ?
                             FRAC_BITS - espi_pkg::GAIN_FRAC : 0;
    localparam int DN_SH   = (FRAC_BITS < espi_pkg::GAIN_FRAC) ?
                             espi_pkg::GAIN_FRAC - FRAC_BITS : 0;
    localparam int DELTA_W = GP_W + 1 + UP_SH;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int DRIVE_W = FRAC_BITS + 4;
    localparam int MUL_W   = DRIVE_W + 10;
    localparam int X_W     = 14;
    localparam int DM_W    = 28;

    localparam logic signed [PROD_W-1:0] SPD_MAX = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SPD_MIN = PROD_W'(-32768);
    localparam logic [DRIVE_W-1:0] DRIVE_TOP =
        DRIVE_W'(espi_pkg::DRIVE_MAX_INT) << FRAC_BITS;

    espi_pkg::t_cfg cfg;

    espi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Pipeline state.
    logic [COUNT_WIDTH-1:0]        r_count;
    logic [COUNT_WIDTH-1:0]        r_last;
    logic signed [ERR_W-1:0]       r_prev_err;
    logic [DRIVE_W-1:0]            r_drive;

    logic                          r_s1_valid;
    logic signed [COUNT_WIDTH-1:0] r_s1_diff;
    logic                          r_s2_valid;
    logic signed [PROD_W-1:0]      r_s2_prod;
    logic                          r_s3_valid;
    logic signed [GP_W-1:0]        r_s3_pnow;
    logic signed [GP_W-1:0]        r_s3_pprev;
    logic [15:0]                   r_s3_speed;
    logic                          r_s4_valid;
    logic [DRIVE_W-1:0]            r_s4_drive;
    logic [15:0]                   r_s4_speed;
    logic                          r_s4_clamped;
    logic                          r_s5_valid;
    logic [X_W-1:0]                r_s5_x;
    logic [15:0]                   r_s5_speed;
    logic                          r_s5_clamped;
    logic                          r_out_valid;
    logic [9:0]                    r_out_duty;
    logic [15:0]                   r_out_speed;
    logic                          r_out_clamped;

    logic rdy_1, rdy_2, rdy_3, rdy_4, rdy_5, rdy_out;
    logic tick_acc, edge_acc;

    assign rdy_out = !r_out_valid || m_axis_tready;
    assign rdy_5   = !r_s5_valid || rdy_out;
    assign rdy_4   = !r_s4_valid || rdy_5;
    assign rdy_3   = !r_s3_valid || rdy_4;
    assign rdy_2   = !r_s2_valid || rdy_3;
    assign rdy_1   = !r_s1_valid || rdy_2;

    assign s_axis_tready = !s_axis_tuser || rdy_1;
    assign tick_acc      = s_axis_tvalid && s_axis_tuser && rdy_1;
    assign edge_acc      = s_axis_tvalid && !s_axis_tuser;

    // Combinational stage logic.
    logic [COUNT_WIDTH-1:0]   n_diff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [15:0]       n_speed;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [GP_W-1:0]   n_pnow;
    logic signed [GP_W-1:0]   n_pprev;
    logic signed [GP_W:0]     n_delta_raw;
    logic signed [DELTA_W-1:0] n_delta_ext;
    logic signed [DELTA_W-1:0] n_delta;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  n_top;
    logic [DRIVE_W-1:0]       n_drive;
    logic                     n_clamped;
    logic [MUL_W-1:0]         n_mul;
    logic [DM_W-1:0]          n_dmul;

    assign n_diff = r_count - r_last;
    assign n_prod = r_s1_diff * $signed({1'b0, cfg.speed_scale});

    always_comb begin
        if (r_s2_prod > SPD_MAX) begin
            n_speed = 16'sh7fff;
        end else if (r_s2_prod < SPD_MIN) begin
            n_speed = -16'sh8000;
        end else begin
            n_speed = r_s2_prod[15:0];
        end
    end

    assign n_err   = ERR_W'($signed(cfg.ref_speed)) - ERR_W'(n_speed);
    assign n_pnow  = $signed({1'b0, cfg.gain_now}) * n_err;
    assign n_pprev = $signed({1'b0, cfg.gain_prev}) * r_prev_err;

    assign n_delta_raw = (GP_W + 1)'(r_s3_pnow) - (GP_W + 1)'(r_s3_pprev);
    assign n_delta_ext = DELTA_W'(n_delta_raw);
    assign n_delta     = (n_delta_ext <<< UP_SH) >>> DN_SH;
    assign n_sum       = SUM_W'(n_delta) + $signed(SUM_W'(r_drive));
    assign n_top       = $signed(SUM_W'(DRIVE_TOP));

    always_comb begin
        if (n_sum > n_top) begin
            n_drive   = DRIVE_TOP;
            n_clamped = 1'b1;
        end else if (n_sum < 0) begin
            n_drive   = '0;
            n_clamped = 1'b1;
        end else begin
            n_drive   = n_sum[DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    assign n_mul  = MUL_W'(r_s4_drive) * MUL_W'(espi_pkg::DUTY_FULL);
    assign n_dmul = DM_W'(r_s5_x) * DM_W'(espi_pkg::DUTY_RECIP);

    // Control state and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= '0;
            r_prev_err  <= '0;
            r_drive     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (edge_acc) begin
                if (s_axis_tdata[0]) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (tick_acc) begin
                r_last <= r_count;
            end
            if (r_s2_valid && rdy_3) begin
                r_prev_err <= n_err;
            end
            if (r_s3_valid && rdy_4) begin
                r_drive <= n_drive;
            end
            if (rdy_1) begin
                r_s1_valid <= tick_acc;
            end
            if (rdy_2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy_3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (rdy_4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (rdy_5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (rdy_out) begin
                r_out_valid <= r_s5_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (rdy_1) begin
            r_s1_diff <= $signed(n_diff);
        end
        if (rdy_2) begin
            r_s2_prod <= n_prod;
        end
        if (rdy_3) begin
            r_s3_pnow  <= n_pnow;
            r_s3_pprev <= n_pprev;
            r_s3_speed <= n_speed;
        end
        if (rdy_4) begin
            r_s4_drive   <= n_drive;
            r_s4_speed   <= r_s3_speed;
            r_s4_clamped <= n_clamped;
        end
        if (rdy_5) begin
            r_s5_x       <= n_mul[FRAC_BITS+X_W-1:FRAC_BITS];
            r_s5_speed   <= r_s4_speed;
            r_s5_clamped <= r_s4_clamped;
        end
        if (rdy_out) begin
            r_out_duty    <= n_dmul[espi_pkg::DUTY_RECIP_SHIFT+9:espi_pkg::DUTY_RECIP_SHIFT];
            r_out_speed   <= r_s5_speed;
            r_out_clamped <= r_s5_clamped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_clamped, r_out_speed, r_out_duty};

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:0] <= 10'd1000)
        else $error("duty beyond full scale");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive <= DRIVE_TOP)
        else $error("drive level beyond upper limit");

    a_clamp_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[26]) |->
        (m_axis_tdata[9:0] == 10'd0 || m_axis_tdata[9:0] == 10'd1000))
        else $error("clamped drive without limit duty");

    a_edge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_acc |=> (r_count == $past(r_count) + 1'b1 ||
                      r_count == $past(r_count) - 1'b1))
        else $error("edge beat did not move count by one");

    a_tick_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> r_s1_valid)
        else $error("accepted tick lost at first stage");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed PI controller testbench
// Streams encoder edges and sample ticks into the controller, predicts every
// tick result in a behavioral copy of the counter and the PI loop, and compares
// each output beat field by field. A short table of directed beats and register
// writes is followed by random phases with different settings and idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 9;
    localparam int DRAIN_PAD   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_BEATS = 115;
    localparam int N_DIRECTED  = 24;
    localparam int HOLD_PHASE  = 2;
    localparam int PAUSE_PHASE = 5;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ROW_EDGE,
        ROW_TICK,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [9:0]  duty;
        logic [15:0] speed;
        logic        clamped;
    } t_ctrl_result;

    typedef struct packed {
        t_row_kind           kind;
        logic                phase_b;
        espi_pkg::t_reg_idx  reg_idx;
        logic [15:0]         value;
        logic                known;
        t_ctrl_result        result;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [0] phase_b
    logic        s_axis_tuser = 1'b0;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;          // [9:0] pwm_duty, [25:10] speed, [26] drive_clamped
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [espi_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [espi_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [espi_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    // Behavioral copy of the controller state and its registers.
    logic [15:0] pos_count = '0;
    logic [15:0] pos_at_tick = '0;
    longint      last_error = 0;
    longint      drive_now = 0;
    logic [15:0] cfg_ref = espi_pkg::RST_REF_SPEED;
    logic [15:0] cfg_scale = espi_pkg::RST_SPEED_SCALE;
    logic [15:0] cfg_gain_now = espi_pkg::RST_GAIN_NOW;
    logic [15:0] cfg_gain_prev = espi_pkg::RST_GAIN_PREV;

    t_ctrl_result pending_results[$];
    t_stim_row    directed_rows [N_DIRECTED];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_req = 0;
    int           hold_left = 0;
    int           cycle_count = 0;

    encoder_speed_pi_controller_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_stim_row row(input t_row_kind kind, input logic pb,
                                      input espi_pkg::t_reg_idx idx, input logic [15:0] value,
                                      input logic known, input logic [9:0] duty,
                                      input logic [15:0] speed, input logic clamped);
        t_stim_row r;
        r.kind = kind;
        r.phase_b = pb;
        r.reg_idx = idx;
        r.value = value;
        r.known = known;
        r.result.duty = duty;
        r.result.speed = speed;
        r.result.clamped = clamped;
        return r;
    endfunction

    // Moves the position count on an edge; on a tick runs the speed measure
    // and the incremental PI update and returns the result beat.
    function automatic bit predict_control_step(input t_op op, input logic pb,
                                                output t_ctrl_result res);
        logic [15:0] count_delta;
        longint      diff;
        longint      scale_v;
        longint      ref_v;
        longint      spd;
        longint      err;
        longint      gnow_v;
        longint      gprev_v;
        longint      sum;
        longint      top;
        logic        clamped;
        res = '0;
        if (op == OP_EDGE) begin
            pos_count = pb ? pos_count + 16'd1 : pos_count - 16'd1;
            return 1'b0;
        end
        count_delta = pos_count - pos_at_tick;
        diff = $signed(count_delta);
        pos_at_tick = pos_count;
        scale_v = cfg_scale;
        spd = diff * scale_v;
        if (spd > 32767) spd = 32767;
        if (spd < -32768) spd = -32768;
        ref_v = $signed(cfg_ref);
        err = ref_v - spd;
        gnow_v = cfg_gain_now;
        gprev_v = cfg_gain_prev;
        top = longint'(espi_pkg::DRIVE_MAX_INT) << espi_pkg::GAIN_FRAC;
        sum = drive_now + gnow_v * err - gprev_v * last_error;
        last_error = err;
        clamped = 1'b0;
        if (sum > top) begin
            sum = top;
            clamped = 1'b1;
        end else if (sum < 0) begin
            sum = 0;
            clamped = 1'b1;
        end
        drive_now = sum;
        res.duty = 10'((drive_now * espi_pkg::DUTY_FULL) / top);
        res.speed = 16'(spd);
        res.clamped = clamped;
        return 1'b1;
    endfunction

    task automatic send_beat(input t_op op, input logic pb, input logic known,
                             input t_ctrl_result known_res);
        int           gap;
        bit           has_res;
        t_ctrl_result res;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, pb};
        do @(posedge i_clk); while (!s_axis_tready);
        has_res = predict_control_step(op, pb, res);
        if (has_res) pending_results.push_back(known ? known_res : res);
    endtask

    task automatic drain(input int pad);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    task automatic write_reg(input espi_pkg::t_reg_idx idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            espi_pkg::REG_REF_SPEED:   cfg_ref = value;
            espi_pkg::REG_SPEED_SCALE: cfg_scale = value;
            espi_pkg::REG_GAIN_NOW:    cfg_gain_now = value;
            espi_pkg::REG_GAIN_PREV:   cfg_gain_prev = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure_phase(input int ph);
        logic [15:0] ref_v;
        logic [15:0] scale_v;
        logic [15:0] gnow_v;
        logic [15:0] gprev_v;
        ref_v = espi_pkg::RST_REF_SPEED;
        scale_v = espi_pkg::RST_SPEED_SCALE;
        gnow_v = espi_pkg::RST_GAIN_NOW;
        gprev_v = espi_pkg::RST_GAIN_PREV;
        case (ph)
            1: ref_v = 16'd1000;
            2: begin
                ref_v = 16'h8000;
                scale_v = 16'hFFFF;
                gnow_v = 16'hFFFF;
                gprev_v = 16'hFFFF;
            end
            3: begin
                ref_v = 16'h7FFF;
                scale_v = 16'd0;
                gnow_v = 16'd0;
                gprev_v = 16'd0;
            end
            4: begin
                ref_v = 16'($urandom);
                scale_v = 16'($urandom_range(500, 1));
                gnow_v = 16'($urandom);
                gprev_v = 16'($urandom);
            end
            5: begin
                ref_v = -16'sd500;
                scale_v = 16'd1;
                gnow_v = 16'hFFFF;
                gprev_v = 16'd0;
            end
            6: begin
                ref_v = 16'($urandom);
                scale_v = 16'($urandom);
                gnow_v = 16'($urandom);
                gprev_v = 16'($urandom);
            end
            7: begin
                ref_v = 16'd2000;
                scale_v = 16'd300;
            end
            default: ;
        endcase
        write_reg(espi_pkg::REG_REF_SPEED, ref_v);
        write_reg(espi_pkg::REG_SPEED_SCALE, scale_v);
        write_reg(espi_pkg::REG_GAIN_NOW, gnow_v);
        write_reg(espi_pkg::REG_GAIN_PREV, gprev_v);
    endtask

    // Output side: random stalls, a long hold-off on request, and the check.
    always @(posedge i_clk) begin
        t_ctrl_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with none expected: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[9:0] !== want.duty) begin
                    $error("pwm_duty: expected %0d, got %0d", want.duty, m_axis_tdata[9:0]);
                    mismatches++;
                end
                if (m_axis_tdata[25:10] !== want.speed) begin
                    $error("speed: expected %0d, got %0d", $signed(want.speed),
                           $signed(m_axis_tdata[25:10]));
                    mismatches++;
                end
                if (m_axis_tdata[26] !== want.clamped) begin
                    $error("drive_clamped: expected %0d, got %0d", want.clamped,
                           m_axis_tdata[26]);
                    mismatches++;
                end
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int ph;
        int sent;
        int n;
        logic dir;
        logic pb;
        directed_rows = '{
            row(ROW_TICK, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b1, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b1, 10'd0, 16'd300, 1'b1),
            row(ROW_EDGE, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_REF_SPEED, 16'h7FFF, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_SPEED_SCALE, 16'hFFFF, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_GAIN_NOW, 16'hFFFF, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_GAIN_PREV, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b1, 10'd1000, 16'h8000, 1'b1),
            row(ROW_EDGE, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_GAIN_PREV, 16'hFFFF, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_REF_SPEED, 16'h8000, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b0, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_CFG, 1'b0, espi_pkg::REG_SPEED_SCALE, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_EDGE, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0),
            row(ROW_TICK, 1'b1, espi_pkg::REG_REF_SPEED, 16'd0, 1'b0, 10'd0, 16'd0, 1'b0)
        };
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain(DRAIN_PAD);
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_beat(directed_rows[i].kind == ROW_TICK ? OP_TICK : OP_EDGE,
                          directed_rows[i].phase_b, directed_rows[i].known,
                          directed_rows[i].result);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain(DRAIN_PAD);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 64; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 64; end
                default: begin send_idle_pct = 35; recv_idle_pct = 35; end
            endcase
            configure_phase(ph);
            sent = 0;
            if (ph == HOLD_PHASE) begin
                // Output held off while ticks keep coming, so the pipeline fills.
                hold_req = HOLD_CYCLES;
                repeat (24) begin
                    send_beat(OP_TICK, 1'($urandom_range(1)), 1'b0, '0);
                    sent++;
                end
            end
            while (sent < PHASE_BEATS) begin
                if (ph == PAUSE_PHASE && sent >= PHASE_BEATS / 2
                    && sent < PHASE_BEATS / 2 + 20) begin
                    drain(0);
                    sent = PHASE_BEATS / 2 + 20;
                end
                dir = 1'($urandom_range(1));
                n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(16);
                repeat (n) begin
                    pb = ($urandom_range(99) < 85) ? dir : 1'($urandom_range(1));
                    send_beat(OP_EDGE, pb, 1'b0, '0);
                    sent++;
                end
                send_beat(OP_TICK, 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end
        end

        drain(DRAIN_PAD);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
